>>> sv/lidar_polar_to_xy_zone_guard_assert.svh
// Assertion macros for the lidar polar-to-XY guard block.
// Depends on nothing; the asserting module provides clk_i and rst_ni.
`ifndef LIDAR_POLAR_TO_XY_ZONE_GUARD_ASSERT_SVH
`define LIDAR_POLAR_TO_XY_ZONE_GUARD_ASSERT_SVH

// Clocked check, disabled while reset is asserted
`ifndef SYNTHESIS
`define LPXZ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lpxz check failed");
`else
`define LPXZ_ASSERT(label, prop)
`endif

// Clocked check that also holds during reset
`ifndef SYNTHESIS
`define LPXZ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("lpxz check failed");
`else
`define LPXZ_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> sv/lpxz_pkg.sv
// Package for the lidar polar-to-XY guard block: widths, register codes,
// reset values and the elaboration-time quarter-wave sine table builder.
// No dependencies.
package lpxz_pkg;

  // Table geometry and fixed-point formats
  localparam int ROM_ADDR_W  = 10;
  localparam int TRIG_FRAC_W = 15;
  localparam int ROM_DEPTH   = 1 << ROM_ADDR_W;
  localparam int TRIG_W      = TRIG_FRAC_W + 1;

  localparam int ANGLE_W = 24;
  localparam int RANGE_W = 16;
  localparam int ZONE_W  = 16;
  localparam int POS_W   = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register reset values (0.05 m, 0.30 m, 0.20 m in 1/1024 m)
  localparam logic [ZONE_W-1:0] ZONE_X_MIN_RST  = 16'd51;
  localparam logic [ZONE_W-1:0] ZONE_X_MAX_RST  = 16'd307;
  localparam logic [ZONE_W-1:0] ZONE_Y_HALF_RST = 16'd204;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_ANGLE,
    CFG_ANGLE_STEP,
    CFG_ZONE_X_MIN,
    CFG_ZONE_X_MAX,
    CFG_ZONE_Y_HALF
  } cfg_reg_e;

  // Taylor series constants, Q30 angle
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam int          TAYLOR_TERMS = 9;
  localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
  };

  typedef logic [TRIG_W-1:0] sine_rom_t [ROM_DEPTH];

  // Builds sin(pi/2 * k/N) in Q(TRIG_FRAC_W), k = 0 .. N-1; used for constants only
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sum;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      x   = (64'(k) * HALF_PI_Q30) >> ROM_ADDR_W;
      x2  = (x * x) >> 30;
      t   = x;
      sum = x;
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
        t = ((t * x2) >> 30) / TAYLOR_DIV[n];
        if ((n % 2) == 1) begin
          sum = sum - t;
        end else begin
          sum = sum + t;
        end
      end
      rom[k] = TRIG_W'((sum + (64'd1 << (29 - TRIG_FRAC_W))) >> (30 - TRIG_FRAC_W));
    end
    return rom;
  endfunction

endpackage

>>> sv/lidar_polar_to_xy_zone_guard.sv
// Top level of the lidar polar-to-XY converter with forward guard zone.
// Depends on lpxz_pkg and lidar_polar_to_xy_zone_guard_assert.svh.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------
//  cfg     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//  in      | in_valid_i / in_ready_o    | range_sample_i, scan_end_i
//  out     | out_valid_o / out_ready_i  | pos_x_o, pos_y_o, point_in_zone_o,
//          |                            | scan_danger_o, result_last_o
//
// One sample per cycle while the output does not stall; a result passes through
// three registers: sine table read, range-by-trig multiply, then sign, box test
// and output register.
// Each stage moves whenever the stage after it is empty or moving, so a stall
// on the output backs up the chain and in_ready_o drops only when all three are full.
// Reset clears valid bits, the scan angle and the sticky flag, and loads the
// register reset values; the sine table is constant and needs no fill.
`include "lidar_polar_to_xy_zone_guard_assert.svh"

module lidar_polar_to_xy_zone_guard import lpxz_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // sample input
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [RANGE_W-1:0]       range_sample_i,
  input  logic                     scan_end_i,
  // point output
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [POS_W-1:0]  pos_x_o,
  output logic signed [POS_W-1:0]  pos_y_o,
  output logic                     point_in_zone_o,
  output logic                     scan_danger_o,
  output logic                     result_last_o
);

  localparam sine_rom_t          SINE_ROM   = build_sine_rom();
  localparam logic [TRIG_W-1:0]  TRIG_ONE   = TRIG_W'(1) << TRIG_FRAC_W;
  localparam int                 PROD_W     = RANGE_W + TRIG_W + 1;
  localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(1) << (TRIG_FRAC_W - 1);
  localparam int                 PHASE_W    = ROM_ADDR_W + 2;

  // range * |trig|, rounded half up, saturated to the range maximum
  function automatic logic [RANGE_W-1:0] scale_mag(input logic [RANGE_W-1:0] rng,
                                                   input logic [TRIG_W-1:0]  mag);
    logic [PROD_W-1:0]  prod;
    logic [RANGE_W:0]   scaled;
    prod   = PROD_W'(rng) * PROD_W'(mag) + ROUND_HALF;
    scaled = prod[TRIG_FRAC_W +: RANGE_W + 1];
    return scaled[RANGE_W] ? {RANGE_W{1'b1}} : scaled[RANGE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ANGLE_W-1:0] start_angle_q;
  logic [ANGLE_W-1:0] angle_step_q;
  logic [ZONE_W-1:0]  zone_x_min_q;
  logic [ZONE_W-1:0]  zone_x_max_q;
  logic [ZONE_W-1:0]  zone_y_half_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_angle_q <= '0;
      angle_step_q  <= '0;
      zone_x_min_q  <= ZONE_X_MIN_RST;
      zone_x_max_q  <= ZONE_X_MAX_RST;
      zone_y_half_q <= ZONE_Y_HALF_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_START_ANGLE: start_angle_q <= cfg_data_i[ANGLE_W-1:0];
        CFG_ANGLE_STEP:  angle_step_q  <= cfg_data_i[ANGLE_W-1:0];
        CFG_ZONE_X_MIN:  zone_x_min_q  <= cfg_data_i[ZONE_W-1:0];
        CFG_ZONE_X_MAX:  zone_x_max_q  <= cfg_data_i[ZONE_W-1:0];
        CFG_ZONE_Y_HALF: zone_y_half_q <= cfg_data_i[ZONE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage enables
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic en1, en2, en3;
  logic in_take;

  assign en3        = !out_valid_q || out_ready_i;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1;
  assign in_take    = in_valid_i && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) s1_valid_q  <= in_valid_i;
      if (en2) s2_valid_q  <= s1_valid_q;
      if (en3) out_valid_q <= s2_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Scan angle accumulator and table addressing
  // ---------------------------------------------------------------------------
  logic [ANGLE_W-1:0]    angle_offset_q;
  logic [ANGLE_W-1:0]    angle_d;
  logic [PHASE_W-1:0]    phase;
  logic [ROM_ADDR_W-1:0] addr_a;
  logic [ROM_ADDR_W-1:0] addr_b;

  assign angle_d = start_angle_q + angle_offset_q;
  assign phase   = angle_d[ANGLE_W-1 -: PHASE_W];
  assign addr_a  = phase[ROM_ADDR_W-1:0];
  assign addr_b  = ~addr_a + 1'b1;  // N - k; k == 0 maps to the full-scale flag

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_offset_q <= '0;
    end else if (in_take) begin
      angle_offset_q <= scan_end_i ? '0 : angle_offset_q + angle_step_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: sine table read, two ports (k and N-k)
  // ---------------------------------------------------------------------------
  logic [TRIG_W-1:0]  rom_a_q, rom_b_q;
  logic               s1_full_q;
  logic [1:0]         s1_quad_q;
  logic [RANGE_W-1:0] s1_range_q;
  logic               s1_last_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      rom_a_q    <= SINE_ROM[addr_a];
      rom_b_q    <= SINE_ROM[addr_b];
      s1_full_q  <= (addr_a == '0);
      s1_quad_q  <= phase[PHASE_W-1 -: 2];
      s1_range_q <= range_sample_i;
      s1_last_q  <= scan_end_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: quadrant folding and range scaling
  // ---------------------------------------------------------------------------
  logic [TRIG_W-1:0]  mag_b, sin_mag, cos_mag;
  logic [RANGE_W-1:0] s2_x_mag_q, s2_y_mag_q;
  logic               s2_x_neg_q, s2_y_neg_q, s2_last_q;

  assign mag_b   = s1_full_q ? TRIG_ONE : rom_b_q;
  assign sin_mag = s1_quad_q[0] ? mag_b : rom_a_q;
  assign cos_mag = s1_quad_q[0] ? rom_a_q : mag_b;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_x_mag_q <= scale_mag(s1_range_q, cos_mag);
      s2_y_mag_q <= scale_mag(s1_range_q, sin_mag);
      s2_x_neg_q <= s1_quad_q[1] ^ s1_quad_q[0];  // cosine negative in quadrants 1, 2
      s2_y_neg_q <= s1_quad_q[1];                 // sine negative in quadrants 2, 3
      s2_last_q  <= s1_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: sign, guard box test, sticky scan flag, output register
  // ---------------------------------------------------------------------------
  logic signed [POS_W-1:0] x_val, y_val;
  logic signed [POS_W-1:0] x_min_s, x_max_s;
  logic                    in_zone, sticky;
  logic                    danger_seen_q;
  logic signed [POS_W-1:0] pos_x_q, pos_y_q;
  logic                    in_zone_q, scan_danger_q, last_q;

  assign x_val   = s2_x_neg_q ? -$signed({1'b0, s2_x_mag_q}) : $signed({1'b0, s2_x_mag_q});
  assign y_val   = s2_y_neg_q ? -$signed({1'b0, s2_y_mag_q}) : $signed({1'b0, s2_y_mag_q});
  assign x_min_s = $signed({1'b0, zone_x_min_q});
  assign x_max_s = $signed({1'b0, zone_x_max_q});
  assign in_zone = (x_val > x_min_s) && (x_val < x_max_s) && (s2_y_mag_q < zone_y_half_q);
  assign sticky  = danger_seen_q || in_zone;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      danger_seen_q <= 1'b0;
    end else if (en3 && s2_valid_q) begin
      danger_seen_q <= s2_last_q ? 1'b0 : sticky;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      pos_x_q       <= x_val;
      pos_y_q       <= y_val;
      in_zone_q     <= in_zone;
      scan_danger_q <= s2_last_q && sticky;
      last_q        <= s2_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = pos_x_q;
  assign pos_y_o         = pos_y_q;
  assign point_in_zone_o = in_zone_q;
  assign scan_danger_o   = scan_danger_q;
  assign result_last_o   = last_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `LPXZ_ASSERT(a_full_backs_up, !in_ready_o |-> (out_valid_o && !out_ready_i))
  `LPXZ_ASSERT(a_sticky_clears, (en3 && s2_valid_q && s2_last_q) |=> !danger_seen_q)
  `LPXZ_ASSERT(a_danger_on_last, (out_valid_o && scan_danger_o) |-> result_last_o)
  `LPXZ_ASSERT(a_zone_forward, (out_valid_o && point_in_zone_o) |-> ($signed(pos_x_o) > 0))
  `LPXZ_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o)

endmodule

>>> test/tb_lidar_polar_to_xy_zone_guard.sv
`timescale 1ns / 1ps
// Testbench for lidar_polar_to_xy_zone_guard. It sends range requests and register writes,
// predicts each point from its own sine table and scan state, and checks every output field.
// Depends on lpxz_pkg and the block's RTL.
module tb_lidar_polar_to_xy_zone_guard;
  import lpxz_pkg::*;

  localparam int PIPE_LATENCY = 3;
  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 1350;
  localparam int MAX_REPORTS  = 30;
  // first index past the register list; writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(CFG_ZONE_Y_HALF) + 1'b1;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             in_zone;
    logic             danger;
    logic             last;
  } scan_point_t;

  // DUT ports
  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    cfg_valid_i     = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i      = '0;
  logic                    in_valid_i      = 1'b0;
  logic                    in_ready_o;
  logic [RANGE_W-1:0]      range_sample_i  = '0;
  logic                    scan_end_i      = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i     = 1'b0;
  logic signed [POS_W-1:0] pos_x_o;
  logic signed [POS_W-1:0] pos_y_o;
  logic                    point_in_zone_o;
  logic                    scan_danger_o;
  logic                    result_last_o;

  // predictor copy of the registers and scan state
  logic [ANGLE_W-1:0] cfg_start   = '0;
  logic [ANGLE_W-1:0] cfg_step    = '0;
  logic [ZONE_W-1:0]  cfg_x_min   = ZONE_X_MIN_RST;
  logic [ZONE_W-1:0]  cfg_x_max   = ZONE_X_MAX_RST;
  logic [ZONE_W-1:0]  cfg_y_half  = ZONE_Y_HALF_RST;
  logic [ANGLE_W-1:0] scan_offset = '0;
  logic               scan_hazard = 1'b0;

  logic [TRIG_W-1:0] quarter_wave [0:ROM_DEPTH];
  scan_point_t       expected_points [$];
  int                fail_count   = 0;
  int                quiet_cycles = 0;
  int                steady_left  = 0;

  lidar_polar_to_xy_zone_guard i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .range_sample_i (range_sample_i),
    .scan_end_i     (scan_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .point_in_zone_o(point_in_zone_o),
    .scan_danger_o  (scan_danger_o),
    .result_last_o  (result_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // sin(pi/2 * k/N) in Q(TRIG_FRAC_W): Q30 Taylor sum up to x^19, rounded half up
  function automatic logic [TRIG_W-1:0] sine_entry(int k);
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] term;
    logic [63:0] acc;
    if (k >= ROM_DEPTH) return TRIG_W'(64'd1 << TRIG_FRAC_W);
    ang    = (64'(k) * HALF_PI_Q30) >> ROM_ADDR_W;
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = ang;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
      acc  = n[0] ? acc - term : acc + term;
    end
    return TRIG_W'((acc + (64'd1 << (29 - TRIG_FRAC_W))) >> (30 - TRIG_FRAC_W));
  endfunction

  // range times |trig|, rounded half up, clipped, then signed
  function automatic int scale_axis(logic [RANGE_W-1:0] rng, logic [TRIG_W-1:0] mag,
                                    logic neg);
    logic [63:0] prod;
    prod = (64'(rng) * 64'(mag) + (64'd1 << (TRIG_FRAC_W - 1))) >> TRIG_FRAC_W;
    if (prod > 64'd65535) prod = 64'd65535;
    return neg ? -int'(prod) : int'(prod);
  endfunction

  // Point for one range request; advances the scan angle and sticky flag
  function automatic scan_point_t predict_point(logic [RANGE_W-1:0] rng, logic last);
    logic [ANGLE_W-1:0]    angle;
    logic [ROM_ADDR_W+1:0] phase;
    logic [1:0]            sin_quad;
    logic [1:0]            cos_quad;
    int                    idx;
    int                    xv;
    int                    yv;
    int                    y_abs;
    logic                  hit;
    logic                  sticky;
    scan_point_t           pt;
    angle    = cfg_start + scan_offset;
    phase    = angle[ANGLE_W-1 -: ROM_ADDR_W+2];
    sin_quad = phase[ROM_ADDR_W +: 2];
    cos_quad = sin_quad + 2'd1;
    idx      = int'(phase[ROM_ADDR_W-1:0]);
    xv = scale_axis(rng, cos_quad[0] ? quarter_wave[ROM_DEPTH-idx] : quarter_wave[idx],
                    cos_quad[1]);
    yv = scale_axis(rng, sin_quad[0] ? quarter_wave[ROM_DEPTH-idx] : quarter_wave[idx],
                    sin_quad[1]);
    y_abs  = (yv < 0) ? -yv : yv;
    hit    = (xv > int'(cfg_x_min)) && (xv < int'(cfg_x_max)) && (y_abs < int'(cfg_y_half));
    sticky = scan_hazard || hit;
    pt.x       = POS_W'(xv);
    pt.y       = POS_W'(yv);
    pt.in_zone = hit;
    pt.danger  = last && sticky;
    pt.last    = last;
    if (last) begin
      scan_offset = '0;
      scan_hazard = 1'b0;
    end else begin
      scan_offset = scan_offset + cfg_step;
      scan_hazard = sticky;
    end
    return pt;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < MAX_REPORTS) begin
      $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    end
    fail_count++;
  endtask

  // One range request; valid stays up across back-to-back requests
  task automatic push_sample(input logic [RANGE_W-1:0] rng, input logic last);
    int gap;
    int roll;
    in_valid_i     <= 1'b1;
    range_sample_i <= rng;
    scan_end_i     <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_points.push_back(predict_point(rng, last));
    // mostly short gaps, a few long ones, and now and then a run with none
    gap = 0;
    if (steady_left > 0) begin
      steady_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 2) steady_left = $urandom_range(50, 200);
      else if (roll < 50) gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 3);
      else if (roll < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(15, 40);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off requests until every expected point is back and the pipe is empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_START_ANGLE: cfg_start  = data[ANGLE_W-1:0];
      CFG_ANGLE_STEP:  cfg_step   = data[ANGLE_W-1:0];
      CFG_ZONE_X_MIN:  cfg_x_min  = data[ZONE_W-1:0];
      CFG_ZONE_X_MAX:  cfg_x_max  = data[ZONE_W-1:0];
      CFG_ZONE_Y_HALF: cfg_y_half = data[ZONE_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // New angles and box, extremes included; junk in the unused upper data bits
  task automatic randomize_settings();
    logic [CFG_DATA_W-1:0] ang;
    logic [CFG_DATA_W-1:0] stp;
    logic [ZONE_W-1:0]     xmin;
    logic [ZONE_W-1:0]     xmax;
    logic [ZONE_W-1:0]     yh;
    int                    roll;
    wait_idle();
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      ang = CFG_DATA_W'($urandom);
    end else if (roll < 7) begin
      ang = CFG_DATA_W'($urandom_range(0, 24'h0C0000)) - 24'h060000;
    end else begin
      case ($urandom_range(0, 4))
        0:       ang = 24'h000000;
        1:       ang = 24'hFFFFFF;
        2:       ang = 24'h400000;
        3:       ang = 24'h800000;
        default: ang = 24'hC00000;
      endcase
    end
    roll = $urandom_range(0, 9);
    if (roll < 5) begin
      stp = CFG_DATA_W'($urandom_range(0, 24'h040000)) - 24'h020000;
    end else if (roll < 7) begin
      case ($urandom_range(0, 4))
        0:       stp = 24'h000000;
        1:       stp = 24'h7FFFFF;
        2:       stp = 24'h800000;
        3:       stp = 24'h000001;
        default: stp = 24'hFFFFFF;
      endcase
    end else begin
      stp = CFG_DATA_W'($urandom);
    end
    roll = $urandom_range(0, 9);
    if (roll < 6) begin
      xmin = ZONE_W'($urandom_range(0, 300));
      xmax = xmin + ZONE_W'($urandom_range(1, 1200));
      yh   = ZONE_W'($urandom_range(1, 600));
    end else if (roll < 8) begin
      xmin = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      xmax = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      yh   = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end else begin
      xmin = ZONE_W'($urandom);
      xmax = ZONE_W'($urandom);
      yh   = ZONE_W'($urandom);
    end
    write_register(CFG_START_ANGLE, ang);
    write_register(CFG_ANGLE_STEP, stp);
    write_register(CFG_ZONE_X_MIN, {8'($urandom), xmin});
    write_register(CFG_ZONE_X_MAX, {8'($urandom), xmax});
    write_register(CFG_ZONE_Y_HALF, {8'($urandom), yh});
  endtask

  // One scan of random length; now and then left open without its end marker
  task automatic send_random_scan(output int count);
    int                 len;
    logic               open_end;
    logic [RANGE_W-1:0] rng;
    len      = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
    open_end = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: rng = RANGE_W'($urandom_range(0, 511));
        4, 5, 6:    rng = RANGE_W'($urandom_range(0, 4095));
        7, 8:       rng = RANGE_W'($urandom);
        default: begin
          case ($urandom_range(0, 3))
            0:       rng = 16'h0000;
            1:       rng = 16'h0001;
            2:       rng = 16'hFFFE;
            default: rng = 16'hFFFF;
          endcase
        end
      endcase
      push_sample(rng, (i == len - 1) && !open_end);
    end
    count = len;
  endtask

  // Reset registers: angle 0, so x = range; box edges are exclusive
  task automatic test_reset_defaults();
    push_sample(16'd0, 1'b0);
    push_sample(16'd51, 1'b0);
    push_sample(16'd52, 1'b0);
    push_sample(16'd306, 1'b0);
    push_sample(16'd307, 1'b0);
    push_sample(16'hFFFF, 1'b1);
    push_sample(16'd0, 1'b1);
  endtask

  // Every register written, spare indexes ignored, quadrants and angle wrap
  task automatic test_angle_wrap();
    wait_idle();
    write_register(CFG_ZONE_X_MIN, 24'h000000);
    write_register(CFG_ZONE_X_MAX, 24'h00FFFF);
    write_register(CFG_ZONE_Y_HALF, 24'h00FFFF);
    for (int i = int'(CFG_IDX_SPARE); i < (1 << CFG_IDX_W); i++) begin
      write_register(CFG_IDX_W'(i), 24'h000000);
    end
    // quarter-turn steps from just below a full turn, wrapping past zero
    write_register(CFG_START_ANGLE, 24'hF00000);
    write_register(CFG_ANGLE_STEP, 24'h400000);
    for (int i = 0; i < 5; i++) push_sample(16'hFFFF, i == 4);
    wait_idle();
    // most negative step from the top of the angle range
    write_register(CFG_START_ANGLE, 24'hFFFFFF);
    write_register(CFG_ANGLE_STEP, 24'h800000);
    for (int i = 0; i < 3; i++) push_sample(16'd40000, i == 2);
    wait_idle();
    write_register(CFG_START_ANGLE, 24'h000000);
    write_register(CFG_ANGLE_STEP, 24'h7FFFFF);
    push_sample(16'd1000, 1'b0);
    push_sample(16'd1000, 1'b1);
  endtask

  // Empty and inverted boxes never flag; a one-unit box does
  task automatic test_empty_box();
    wait_idle();
    write_register(CFG_ANGLE_STEP, 24'h000000);
    write_register(CFG_ZONE_X_MIN, 24'd100);
    write_register(CFG_ZONE_X_MAX, 24'd100);
    push_sample(16'd100, 1'b1);
    wait_idle();
    write_register(CFG_ZONE_X_MIN, 24'd200);
    push_sample(16'd150, 1'b1);
    wait_idle();
    write_register(CFG_ZONE_X_MIN, 24'd0);
    write_register(CFG_ZONE_X_MAX, 24'h00FFFF);
    write_register(CFG_ZONE_Y_HALF, 24'd0);
    push_sample(16'd500, 1'b1);
    wait_idle();
    write_register(CFG_ZONE_Y_HALF, 24'd1);
    push_sample(16'd1, 1'b0);
    push_sample(16'hFFFF, 1'b1);
  endtask

  // Sender stops mid-stream until every point is back, then resumes
  task automatic test_sender_pause();
    int count;
    randomize_settings();
    repeat (3) send_random_scan(count);
    wait_idle();
    repeat (3) send_random_scan(count);
  endtask

  task automatic test_random_scans();
    int sent;
    int phase_items;
    int count;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      randomize_settings();
      phase_items = $urandom_range(60, 180);
      while (phase_items > 0) begin
        send_random_scan(count);
        phase_items -= count;
        sent += count;
      end
    end
  endtask

  // Output side: ready runs and stalls of random length
  initial begin
    int   hold;
    logic level;
    hold  = 0;
    level = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold == 0) begin
        level = !level;
        if (level) begin
          hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
        end else begin
          hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
      end
      out_ready_i <= level;
      hold--;
    end
  end

  // Compare each accepted point with the oldest expectation
  always @(posedge clk_i) begin
    scan_point_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_points.size() == 0) begin
        report_mismatch("point with none pending, pos_x", int'(pos_x_o), 0);
      end else begin
        want = expected_points.pop_front();
        if (pos_x_o !== want.x) report_mismatch("pos_x", int'(pos_x_o), int'($signed(want.x)));
        if (pos_y_o !== want.y) report_mismatch("pos_y", int'(pos_y_o), int'($signed(want.y)));
        if (point_in_zone_o !== want.in_zone) begin
          report_mismatch("point_in_zone", int'(point_in_zone_o), int'(want.in_zone));
        end
        if (scan_danger_o !== want.danger) begin
          report_mismatch("scan_danger", int'(scan_danger_o), int'(want.danger));
        end
        if (result_last_o !== want.last) begin
          report_mismatch("result_last", int'(result_last_o), int'(want.last));
        end
      end
    end
  end

  // Watchdog: ends the run when no channel moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int k = 0; k <= ROM_DEPTH; k++) quarter_wave[k] = sine_entry(k);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_angle_wrap();
    test_empty_box();
    test_sender_pause();
    test_random_scans();
    wait_idle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
